[sv/smtp_pkg.sv]
// ----------------------------------------------------------------------------
// smtp_pkg
// Types and codes shared by the sorted merge transition pair block.
// ----------------------------------------------------------------------------
`default_nettype none

package smtp_pkg;

  localparam int IDX_W = 5;
  localparam int TS_W  = 64;
  localparam int KEY_W = 32;

  localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_RUN        = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [TS_W-1:0]  timestamp;
    logic signed [KEY_W-1:0] sort_key;
    logic                    element_null;
    logic                    ends_only;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic             no_pairs;
    logic             row_null;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP,
    ST_EMIT_A,
    ST_EMIT_B
  } state_t;

endpackage

`default_nettype wire

[sv/smtp_ram.sv]
// ----------------------------------------------------------------------------
// smtp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module smtp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/sorted_merge_transition_pairs.sv]
// ----------------------------------------------------------------------------
// sorted_merge_transition_pairs
// Two-way merge of two sorted event lists, reporting each side switch as a
// pair of left/right local indexes, optionally only the first and last.
// ----------------------------------------------------------------------------
// Load beats are accepted back to back while the block is idle.
// A run beat walks both lists through one shared compare unit: each merged
// element takes a RAM read, then a compare, and the walk waits while the
// output side stalls.
// Reset clears the list counts, the null/overflow flags and the sort key
// enable; the list RAMs are not reset.
`default_nettype none

module sorted_merge_transition_pairs #(
  parameter int LIST_DEPTH = 32,
  parameter int KEY_WIDTH  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire smtp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output smtp_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata
);

  localparam int AW    = $clog2(LIST_DEPTH);
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int KB    = (KEY_WIDTH < smtp_pkg::KEY_W) ? KEY_WIDTH : smtp_pkg::KEY_W;
  localparam int TW    = smtp_pkg::TS_W;
  localparam int WW    = TW + KB;
  localparam int IdxW  = smtp_pkg::IDX_W;
  localparam logic [CW-1:0] DepthC = CW'(LIST_DEPTH);

  smtp_pkg::state_t state_r, state_nxt;

  logic          use_keys_r;
  logic [CW-1:0] lcnt_r, rcnt_r;
  logic          null_seen_r, ovf_seen_r;
  logic          null_run_r, flo_r;
  logic [CW-1:0] li_r, ri_r;
  logic          have_prev_r, prev_left_r;
  logic [AW-1:0] prev_idx_r;
  logic          par_r;
  logic          a_valid_r, b_valid_r;
  logic [AW-1:0] a_li_r, a_ri_r, b_li_r, b_ri_r;
  logic          out_valid_r;
  smtp_pkg::out_item_t out_r;

  logic [WW-1:0] l_word, r_word, wword;
  logic          we_l, we_r;

  logic          load_l, load_r, run_go;
  logic          l_more, r_more, exhausted;
  logic          take_left, sw;
  logic [AW-1:0] idx, sw_li, sw_ri;
  logic          out_free, stall, advance, out_load, finish;
  smtp_pkg::out_item_t out_nxt;

  assign wword = {in_data.timestamp, in_data.sort_key[KB-1:0]};

  smtp_ram #(.WIDTH(WW), .DEPTH(LIST_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (we_l),
    .waddr (lcnt_r[AW-1:0]),
    .wdata (wword),
    .raddr (li_r[AW-1:0]),
    .rdata (l_word)
  );

  smtp_ram #(.WIDTH(WW), .DEPTH(LIST_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (we_r),
    .waddr (rcnt_r[AW-1:0]),
    .wdata (wword),
    .raddr (ri_r[AW-1:0]),
    .rdata (r_word)
  );

  // Command decode on the input beat
  always_comb begin
    load_l = 1'b0;
    load_r = 1'b0;
    run_go = 1'b0;
    if (in_valid && in_ready) begin
      unique case (in_data.cmd)
        smtp_pkg::CMD_LOAD_LEFT:  load_l = 1'b1;
        smtp_pkg::CMD_LOAD_RIGHT: load_r = 1'b1;
        smtp_pkg::CMD_RUN:        run_go = 1'b1;
        default:                  ;
      endcase
    end
  end

  assign we_l = load_l && (lcnt_r < DepthC);
  assign we_r = load_r && (rcnt_r < DepthC);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smtp_pkg::ST_IDLE: begin
        if (run_go) begin
          state_nxt = (null_seen_r || ovf_seen_r) ? smtp_pkg::ST_EMIT_A
                                                  : smtp_pkg::ST_FETCH;
        end
      end
      smtp_pkg::ST_FETCH: begin
        state_nxt = exhausted ? smtp_pkg::ST_EMIT_A : smtp_pkg::ST_STEP;
      end
      smtp_pkg::ST_STEP: begin
        if (!stall) begin
          state_nxt = smtp_pkg::ST_FETCH;
        end
      end
      smtp_pkg::ST_EMIT_A: begin
        if (out_free) begin
          state_nxt = (!null_run_r && flo_r && a_valid_r && b_valid_r)
                      ? smtp_pkg::ST_EMIT_B : smtp_pkg::ST_IDLE;
        end
      end
      smtp_pkg::ST_EMIT_B: begin
        if (out_free) begin
          state_nxt = smtp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smtp_pkg::ST_IDLE;
    endcase
  end

  // Shared compare unit and result selection
  always_comb begin
    l_more    = li_r < lcnt_r;
    r_more    = ri_r < rcnt_r;
    exhausted = !l_more && !r_more;
    if (l_more && r_more) begin
      if ($signed(l_word[WW-1:KB]) < $signed(r_word[WW-1:KB])) begin
        take_left = 1'b1;
      end else if (l_word[WW-1:KB] == r_word[WW-1:KB]) begin
        take_left = !(use_keys_r && ($signed(l_word[KB-1:0]) > $signed(r_word[KB-1:0])));
      end else begin
        take_left = 1'b0;
      end
    end else begin
      take_left = l_more;
    end
    idx   = take_left ? li_r[AW-1:0] : ri_r[AW-1:0];
    sw    = have_prev_r && (prev_left_r != take_left);
    sw_li = prev_left_r ? prev_idx_r : idx;
    sw_ri = prev_left_r ? idx : prev_idx_r;

    out_free = !out_valid_r || out_ready;
    in_ready = (state_r == smtp_pkg::ST_IDLE);
    stall    = 1'b0;
    advance  = 1'b0;
    out_load = 1'b0;
    finish   = 1'b0;
    out_nxt  = '0;

    unique case (state_r)
      smtp_pkg::ST_STEP: begin
        // In streaming mode a new switch pushes out the one held before it
        if (sw && !flo_r && a_valid_r) begin
          stall    = !out_free;
          out_load = out_free;
          out_nxt.left_index  = IdxW'(a_li_r);
          out_nxt.right_index = IdxW'(a_ri_r);
        end
        advance = !stall;
      end
      smtp_pkg::ST_EMIT_A: begin
        out_load = out_free;
        out_nxt.last = 1'b1;
        if (null_run_r) begin
          out_nxt.row_null = 1'b1;
        end else if (!a_valid_r) begin
          out_nxt.no_pairs = 1'b1;
        end else begin
          out_nxt.left_index  = IdxW'(a_li_r);
          out_nxt.right_index = IdxW'(a_ri_r);
          out_nxt.last        = !(flo_r && b_valid_r);
        end
        finish = out_free && (null_run_r || !flo_r || !a_valid_r || !b_valid_r);
      end
      smtp_pkg::ST_EMIT_B: begin
        out_load = out_free;
        out_nxt.left_index  = IdxW'(b_li_r);
        out_nxt.right_index = IdxW'(b_ri_r);
        out_nxt.last        = 1'b1;
        finish = out_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smtp_pkg::ST_IDLE;
      use_keys_r  <= 1'b0;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      null_seen_r <= 1'b0;
      ovf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      have_prev_r <= 1'b0;
      par_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        use_keys_r <= cfg_wdata;
      end
      if (load_l || load_r) begin
        if (in_data.element_null) begin
          null_seen_r <= 1'b1;
        end
        if (load_l && !we_l || load_r && !we_r) begin
          ovf_seen_r <= 1'b1;
        end
      end
      if (we_l) begin
        lcnt_r <= lcnt_r + CW'(1);
      end
      if (we_r) begin
        rcnt_r <= rcnt_r + CW'(1);
      end
      if (run_go) begin
        a_valid_r   <= 1'b0;
        b_valid_r   <= 1'b0;
        have_prev_r <= 1'b0;
        par_r       <= 1'b0;
      end
      if (advance) begin
        have_prev_r <= 1'b1;
        if (sw) begin
          par_r <= !par_r;
          if (!flo_r || !a_valid_r) begin
            a_valid_r <= 1'b1;
          end
          if (flo_r && par_r) begin
            b_valid_r <= 1'b1;
          end
        end
      end
      if (finish) begin
        lcnt_r      <= '0;
        rcnt_r      <= '0;
        null_seen_r <= 1'b0;
        ovf_seen_r  <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      li_r <= '0;
      ri_r <= '0;
    end else if (run_go) begin
      li_r <= '0;
      ri_r <= '0;
    end else if (advance) begin
      if (take_left) begin
        li_r <= li_r + CW'(1);
      end else begin
        ri_r <= ri_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_go) begin
      null_run_r <= null_seen_r || ovf_seen_r;
      flo_r      <= in_data.ends_only;
    end
    if (advance) begin
      prev_left_r <= take_left;
      prev_idx_r  <= idx;
      // Slot A holds the latest switch, or in first/last mode the first one
      if (sw && (!flo_r || !a_valid_r)) begin
        a_li_r <= sw_li;
        a_ri_r <= sw_ri;
      end
      // Slot B holds the latest switch that starts on the other side
      if (sw && flo_r && par_r) begin
        b_li_r <= sw_li;
        b_ri_r <= sw_ri;
      end
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
